[sv/pcg_pkg.sv]
// Shared types and constants for the bounded PCG32 generator.
`timescale 1ns / 1ps
package pcg_pkg;
    localparam logic [63:0] RESET_MULT = 64'd6364136223846793005;
    localparam int          MAX_DRAWS  = 256;

    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_STREAM = 2'd1;
    localparam logic [1:0] CFG_MULT   = 2'd2;

    // Command to the shared iterative unit.
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_MOD = 2'd1
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } unit_cmd_t;

    // XSH-RR output permutation of one state value.
    function automatic logic [31:0] pcg_out(input logic [63:0] s);
        logic [31:0] x;
        logic [4:0]  r;
        begin
            x = 32'(((s >> 18) ^ s) >> 27);
            r = s[63:59];
            pcg_out = (x >> r) | (x << ((6'd32 - {1'b0, r}) & 6'd31));
        end
    endfunction
endpackage

[sv/pcg_unit.sv]
// Shared shift-add multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module pcg_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  pcg_pkg::unit_cmd_t cmd,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic [63:0]       result,
    output logic              done
);
    import pcg_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    op_t         op_reg, op_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        trial     = {acc_reg, opa_reg[63]} - {1'b0, opb_reg};
        if (cmd.start)
        begin
            acc_next  = '0;
            opa_next  = a;
            opb_next  = b;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
            op_next   = cmd.op;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                // Multiplier bits are taken LSB first; the multiplicand shifts up.
                if (opb_reg[0])
                    acc_next = acc_reg + opa_reg;
                opa_next = opa_reg << 1;
                opb_next = opb_reg >> 1;
            end
            else
            begin
                // Remainder of opa by opb, one dividend bit a cycle.
                if (!trial[64])
                    acc_next = trial[63:0];
                else
                    acc_next = {acc_reg[62:0], opa_reg[63]};
                opa_next = opa_reg << 1;
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;
endmodule

[sv/pcg32_bounded_random_generator.sv]
// Top level of the PCG32 generator with bounded integer draws.
// Usage: an input beat (req_type, range_low, range_high) is taken when
// in_valid is high and in_stall is low. Each request yields exactly one
// output beat on value, held in an output register until out_stall is low.
// A raw request (req_type 0) returns one 32-bit XSH-RR word; a bounded
// request returns range_low plus a word reduced modulo the range, with words
// below 2^64 mod range rejected, at most 256 draws per request.
// Every multiply and modulo runs through one shared unit, one bit per cycle:
// both the state advances and the range reductions use it.
// An empty range answers without a draw. The next request is taken only
// after the result beat has been accepted.
// Reset loads the register defaults and runs the seeding sequence (two
// advances) before the first request is taken. Writing the seed or
// stream register reruns the seeding sequence.
// The configuration port is ready only while the block is idle.
// While out_stall is high the result holds, and no new request is taken.
`timescale 1ns / 1ps
module pcg32_bounded_random_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [32:0] value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import pcg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEED0  = 9'b000000010,
        S_SEED1  = 9'b000000100,
        S_THRESH = 9'b000001000,
        S_DRAW   = 9'b000010000,
        S_ADV    = 9'b000100000,
        S_MOD    = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_START  = 9'b100000000
    } state_t;

    state_t      st_reg, st_next;
    logic [63:0] seed_reg, seed_next;
    logic [62:0] stream_reg, stream_next;
    logic [63:0] mult_reg, mult_next;
    logic [63:0] lcg_reg, lcg_next;
    logic        req_reg, req_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] range_reg, range_next;
    logic [31:0] thresh_reg, thresh_next;
    logic [31:0] word_reg, word_next;
    logic [8:0]  tries_reg, tries_next;
    logic        seeding_reg, seeding_next;
    logic        out_v_reg, out_v_next;
    logic [32:0] val_reg, val_next;
    unit_cmd_t   cmd;
    logic [63:0] ua, ub, ures;
    logic        udone;
    logic [63:0] inc;
    logic [32:0] diff;

    pcg_unit u_unit (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .a(ua), .b(ub),
        .result(ures), .done(udone)
    );

    assign inc  = {stream_reg, 1'b1};
    assign diff = {range_high[31], range_high} - {range_low[31], range_low};

    always_comb
    begin
        st_next      = st_reg;
        seed_next    = seed_reg;
        stream_next  = stream_reg;
        mult_next    = mult_reg;
        lcg_next     = lcg_reg;
        req_next     = req_reg;
        low_next     = low_reg;
        range_next   = range_reg;
        thresh_next  = thresh_reg;
        word_next    = word_reg;
        tries_next   = tries_reg;
        seeding_next = seeding_reg;
        out_v_next   = out_v_reg;
        val_next     = val_reg;
        cmd.start    = 1'b0;
        cmd.op       = OP_MUL;
        ua           = lcg_reg;
        ub           = mult_reg;
        if (out_v_reg && !out_stall)
            out_v_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    unique case (cfg_index)
                        CFG_SEED:
                        begin
                            seed_next = cfg_data;
                            st_next   = S_START;
                        end
                        CFG_STREAM:
                        begin
                            stream_next = cfg_data[62:0];
                            st_next     = S_START;
                        end
                        CFG_MULT: mult_next = cfg_data;
                        default: ;
                    endcase
                end
                else if (in_valid && !out_v_reg)
                begin
                    req_next   = req_type;
                    low_next   = range_low;
                    range_next = diff[31:0];
                    tries_next = '0;
                    if (!req_type)
                    begin
                        cmd.start = 1'b1;
                        st_next   = S_DRAW;
                        word_next = pcg_out(lcg_reg);
                    end
                    else if (diff[32] || diff == 33'd0)
                    begin
                        val_next = {range_low[31], range_low};
                        st_next  = S_OUT;
                    end
                    else
                    begin
                        // Threshold = (2^64 - range) mod range.
                        cmd.start = 1'b1;
                        cmd.op    = OP_MOD;
                        ua        = 64'd0 - {32'd0, diff[31:0]};
                        ub        = {32'd0, diff[31:0]};
                        st_next   = S_THRESH;
                    end
                end
            end
            S_START:
            begin
                lcg_next     = '0;
                seeding_next = 1'b1;
                cmd.start    = 1'b1;
                ua           = 64'd0;
                st_next      = S_SEED0;
            end
            S_SEED0:
            begin
                if (udone)
                begin
                    cmd.start = 1'b1;
                    ua        = ures + inc + seed_reg;
                    st_next   = S_SEED1;
                end
            end
            S_SEED1:
            begin
                if (udone)
                begin
                    lcg_next     = ures + inc;
                    seeding_next = 1'b0;
                    st_next      = S_IDLE;
                end
            end
            S_THRESH:
            begin
                if (udone)
                begin
                    thresh_next = ures[31:0];
                    cmd.start   = 1'b1;
                    word_next   = pcg_out(lcg_reg);
                    st_next     = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (udone)
                begin
                    lcg_next   = ures + inc;
                    tries_next = tries_reg + 9'd1;
                    st_next    = S_ADV;
                end
            end
            S_ADV:
            begin
                if (!req_reg)
                begin
                    val_next = {1'b0, word_reg};
                    st_next  = S_OUT;
                end
                else if (word_reg < thresh_reg && tries_reg != 9'(MAX_DRAWS))
                begin
                    cmd.start = 1'b1;
                    word_next = pcg_out(lcg_reg);
                    st_next   = S_DRAW;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_MOD;
                    ua        = {32'd0, word_reg};
                    ub        = {32'd0, range_reg};
                    st_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                if (udone)
                begin
                    val_next = {low_reg[31], low_reg} + {1'b0, ures[31:0]};
                    st_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                out_v_next = 1'b1;
                st_next    = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_START;
            seed_reg    <= '0;
            stream_reg  <= 63'd1;
            mult_reg    <= RESET_MULT;
            seeding_reg <= 1'b1;
            out_v_reg   <= 1'b0;
            tries_reg   <= '0;
            req_reg     <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            seed_reg    <= seed_next;
            stream_reg  <= stream_next;
            mult_reg    <= mult_next;
            seeding_reg <= seeding_next;
            out_v_reg   <= out_v_next;
            tries_reg   <= tries_next;
            req_reg     <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg    <= lcg_next;
        low_reg    <= low_next;
        range_reg  <= range_next;
        thresh_reg <= thresh_next;
        word_reg   <= word_next;
        val_reg    <= val_next;
    end

    assign in_stall  = !(st_reg == S_IDLE) || out_v_reg || cfg_valid || seeding_reg;
    assign cfg_ready = (st_reg == S_IDLE);
    assign out_valid = out_v_reg;
    assign value     = val_reg;
endmodule

[sv/pcg_checker.sv]
// Port-level checks for the bounded PCG32 generator, bound to the top level.
`timescale 1ns / 1ps
module pcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [32:0] value,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("result beat changed while stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result appeared the cycle after a request");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while a result waits");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_stall)
        else $error("request taken during a register write");
endmodule

bind pcg32_bounded_random_generator pcg_checker u_pcg_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
